// ===== hw/rtl/slcr_pkg.sv =====
// ============================================================================
// slcr_pkg: shared definitions for the serial line command recognizer
// Line size, character codes, command words and codes, per-cell ref and hit structs.
// ============================================================================
package slcr_pkg;

    // Line buffer sizing; the buffer holds LINE_CAPACITY - 1 characters
    localparam int LINE_CAPACITY = 16;
    localparam int LINE_DEPTH    = LINE_CAPACITY - 1;
    localparam int LEN_W         = $clog2(LINE_CAPACITY);

    // Control characters
    localparam logic [7:0] CHAR_CR = 8'h0D;
    localparam logic [7:0] CHAR_LF = 8'h0A;

    // Command words; last character sits in the low byte
    localparam int         BOOT_LEN  = 5;
    localparam int         RESET_LEN = 6;
    localparam int         STATS_LEN = 6;
    localparam logic [8*BOOT_LEN-1:0]  WORD_BOOT  = "@BOOT";
    localparam logic [8*RESET_LEN-1:0] WORD_RESET = "@RESET";
    localparam logic [8*STATS_LEN-1:0] WORD_STATS = "@STATS";

    // Command codes
    typedef enum logic [1:0] {
        CMD_NONE  = 2'd0,
        CMD_BOOT  = 2'd1,
        CMD_RESET = 2'd2,
        CMD_STATS = 2'd3
    } t_cmd_code;

    // Expected characters for one cell, one per command word
    typedef struct packed {
        logic [7:0] boot;
        logic [7:0] reset;
        logic [7:0] stats;
    } t_cell_ref;

    // Per-cell compare results
    typedef struct packed {
        logic boot;
        logic reset;
        logic stats;
    } t_cell_hit;

endpackage

// ===== hw/rtl/slcr_in_if.sv =====
// ============================================================================
// slcr_in_if: receive byte channel
// Valid/ready channel carrying one received byte and its error flag.
// ============================================================================
interface slcr_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;
    logic       line_error;

    modport source (output valid, output rx_byte, output line_error, input ready);
    modport sink   (input valid, input rx_byte, input line_error, output ready);
endinterface

// ===== hw/rtl/slcr_out_if.sv =====
// ============================================================================
// slcr_out_if: result channel
// Valid/ready channel carrying the command code and restart request.
// ============================================================================
interface slcr_out_if;
    logic       valid;
    logic       ready;
    logic [1:0] command_code;
    logic       restart_request;

    modport source (output valid, output command_code, output restart_request,
                    input ready);
    modport sink   (input valid, input command_code, input restart_request,
                    output ready);
endinterface

// ===== hw/rtl/slcr_cell.sv =====
// ============================================================================
// slcr_cell: one character cell of the line shift chain
// Holds one line character, passes it on when the chain shifts, and compares
// it against the command characters expected at its position.
// ============================================================================
module slcr_cell (
    input  logic                 i_clk,
    input  logic                 i_shift,
    input  logic [7:0]           i_char,
    input  slcr_pkg::t_cell_ref  i_ref,
    output logic [7:0]           o_char,
    output slcr_pkg::t_cell_hit  o_hit
);

    logic [7:0] r_char;

    // Character storage; content is only meaningful below the line length
    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_char <= i_char;
        end
    end

    // Position compares
    always_comb begin
        o_hit.boot  = (r_char == i_ref.boot);
        o_hit.reset = (r_char == i_ref.reset);
        o_hit.stats = (r_char == i_ref.stats);
    end

    assign o_char = r_char;

endmodule

// ===== hw/rtl/serial_line_command_recognizer_unit.sv =====
// ============================================================================
// serial_line_command_recognizer_unit: serial line command recognizer
// Collects received bytes into a line and flags @BOOT, @RESET and @STATS.
// ============================================================================
// Usage:
//   i_in  carries one received byte per word plus a receive error flag.
//   o_out returns exactly one word per input word: command_code (0 none,
//   1 boot, 2 reset, 3 stats) and restart_request.
//   Characters enter a chain of LINE_CAPACITY - 1 cells; the newest sits in
//   cell 0, so each command word is checked by fixed per-cell compares.
//   Carriage returns are skipped; a line feed reports the match and clears
//   the line; a character arriving on a full line clears it and is dropped;
//   an error word clears the line and sets restart_request.
//   The result is registered: it appears in the cycle after the input word is taken.
//   Throughput: one word per cycle while the receiver is ready, set by the single output register.
//   When the receiver stalls, the output register holds its word and input
//   ready drops until that word is taken.
//   Reset clears the line length and the output valid; cell contents are
//   not cleared and need no clearing pass.
// ============================================================================
module serial_line_command_recognizer_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    slcr_in_if.sink     i_in,
    slcr_out_if.source  o_out
);

    localparam int DEPTH = slcr_pkg::LINE_DEPTH;
    localparam int LW    = slcr_pkg::LEN_W;

    logic [LW-1:0]        r_len;
    logic [LW-1:0]        n_len;
    logic                 r_valid;
    logic [1:0]           r_code;
    logic                 r_restart;
    logic                 w_accept;
    logic                 w_shift;
    logic                 w_cr;
    logic                 w_lf;
    logic                 w_full;
    slcr_pkg::t_cmd_code  w_code;
    logic                 w_boot_ok;
    logic                 w_reset_ok;
    logic                 w_stats_ok;

    logic [7:0]              w_chain [DEPTH+1];
    slcr_pkg::t_cell_ref     w_ref   [DEPTH];
    slcr_pkg::t_cell_hit     w_hit   [DEPTH];
    logic [DEPTH-1:0]        w_hit_boot;
    logic [DEPTH-1:0]        w_hit_reset;
    logic [DEPTH-1:0]        w_hit_stats;

    // Handshake and byte classes
    assign i_in.ready = !r_valid || o_out.ready;
    assign w_accept   = i_in.valid && i_in.ready;
    assign w_cr       = (i_in.rx_byte == slcr_pkg::CHAR_CR);
    assign w_lf       = (i_in.rx_byte == slcr_pkg::CHAR_LF);
    assign w_full     = (r_len == LW'(DEPTH));
    assign w_shift    = w_accept && !i_in.line_error && !w_cr && !w_lf && !w_full;

    // Cell chain: newest character enters cell 0
    assign w_chain[0] = i_in.rx_byte;

    for (genvar k = 0; k < DEPTH; k++) begin : g_cell
        if (k < slcr_pkg::BOOT_LEN) begin : g_boot
            assign w_ref[k].boot = slcr_pkg::WORD_BOOT[8*k +: 8];
        end else begin : g_boot_none
            assign w_ref[k].boot = 8'h00;
        end
        if (k < slcr_pkg::RESET_LEN) begin : g_reset
            assign w_ref[k].reset = slcr_pkg::WORD_RESET[8*k +: 8];
        end else begin : g_reset_none
            assign w_ref[k].reset = 8'h00;
        end
        if (k < slcr_pkg::STATS_LEN) begin : g_stats
            assign w_ref[k].stats = slcr_pkg::WORD_STATS[8*k +: 8];
        end else begin : g_stats_none
            assign w_ref[k].stats = 8'h00;
        end

        slcr_cell u_cell (
            .i_clk   (i_clk),
            .i_shift (w_shift),
            .i_char  (w_chain[k]),
            .i_ref   (w_ref[k]),
            .o_char  (w_chain[k+1]),
            .o_hit   (w_hit[k])
        );

        assign w_hit_boot[k]  = w_hit[k].boot;
        assign w_hit_reset[k] = w_hit[k].reset;
        assign w_hit_stats[k] = w_hit[k].stats;
    end

    // Whole-line match: length plus the low cells of the chain
    assign w_boot_ok  = (r_len == LW'(slcr_pkg::BOOT_LEN))
                        && (&w_hit_boot[slcr_pkg::BOOT_LEN-1:0]);
    assign w_reset_ok = (r_len == LW'(slcr_pkg::RESET_LEN))
                        && (&w_hit_reset[slcr_pkg::RESET_LEN-1:0]);
    assign w_stats_ok = (r_len == LW'(slcr_pkg::STATS_LEN))
                        && (&w_hit_stats[slcr_pkg::STATS_LEN-1:0]);

    always_comb begin
        w_code = slcr_pkg::CMD_NONE;
        if (!i_in.line_error && w_lf) begin
            if (w_boot_ok) begin
                w_code = slcr_pkg::CMD_BOOT;
            end else if (w_reset_ok) begin
                w_code = slcr_pkg::CMD_RESET;
            end else if (w_stats_ok) begin
                w_code = slcr_pkg::CMD_STATS;
            end
        end
    end

    // Next line length
    always_comb begin
        n_len = r_len;
        if (w_accept) begin
            if (i_in.line_error || w_lf || (w_full && !w_cr)) begin
                n_len = '0;
            end else if (!w_cr) begin
                n_len = r_len + LW'(1);
            end
        end
    end

    // Length and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len   <= '0;
            r_valid <= 1'b0;
        end else begin
            r_len <= n_len;
            if (w_accept) begin
                r_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_code    <= w_code;
            r_restart <= i_in.line_error;
        end
    end

    assign o_out.valid           = r_valid;
    assign o_out.command_code    = r_code;
    assign o_out.restart_request = r_restart;

`ifndef SYNTHESIS
    a_len_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_len <= LW'(DEPTH))
        else $error("line length beyond buffer depth");

    a_accept_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> r_valid)
        else $error("accepted word produced no result");

    a_error_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && i_in.line_error) |=> (r_len == '0) && r_restart)
        else $error("receive error did not clear line");

    a_restart_no_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && r_restart) |-> (r_code == slcr_pkg::CMD_NONE))
        else $error("command reported with restart request");

    a_cmd_on_lf: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && (w_code != slcr_pkg::CMD_NONE)) |=> (r_len == '0))
        else $error("matched line not cleared");
`endif

endmodule

// ===== tb/tb_top.sv =====
// ============================================================================
// tb_top: testbench for serial_line_command_recognizer_unit
// Drives received bytes and error flags through the input channel with bursty
// timing while the result channel stalls on its own pattern. A line model in
// the bench predicts command_code and restart_request for every word, and a
// checker compares each returned word, in order, with the oldest prediction.
// ============================================================================
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int TOTAL_WORDS = 2000;
    localparam int NOISE_WORDS = 300;
    localparam int IDLE_LIMIT  = 1000;
    localparam int MAX_REPORTS = 10;

    // One result word as the line model predicts it
    typedef struct packed {
        slcr_pkg::t_cmd_code code;
        logic                restart;
    } t_line_result;

    logic i_clk;
    logic i_rst_n;

    slcr_in_if  in_if();
    slcr_out_if out_if();

    serial_line_command_recognizer_unit dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    // Line model state
    logic [7:0] line_text [slcr_pkg::LINE_DEPTH];
    int         line_len;

    t_line_result pending_results[$];

    int words_sent;
    int burst_left;
    int mismatch_count;
    int results_seen;
    int boot_seen, reset_seen, stats_seen, restart_seen;
    int overflow_drops;
    int idle_cycles;

    // Receiver stall pattern
    int rx_mode;
    int rx_mode_left;
    int rx_phase;

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------------
    // Line model
    // ------------------------------------------------------------------------
    function automatic bit line_holds(input logic [47:0] word, input int len);
        if (line_len != len) return 1'b0;
        for (int i = 0; i < len; i++) begin
            // first character of the word sits in the top byte
            if (line_text[i] != word[8*(len-1-i) +: 8]) return 1'b0;
        end
        return 1'b1;
    endfunction

    function automatic t_line_result predict_line_result(input logic [7:0] rx_char,
                                                          input logic err);
        t_line_result res;
        res.code    = slcr_pkg::CMD_NONE;
        res.restart = 1'b0;
        if (err) begin
            line_len    = 0;
            res.restart = 1'b1;
        end else if (rx_char == slcr_pkg::CHAR_CR) begin
            // carriage return: no effect on the line
        end else if (rx_char == slcr_pkg::CHAR_LF) begin
            if (line_holds(slcr_pkg::WORD_BOOT, slcr_pkg::BOOT_LEN))
                res.code = slcr_pkg::CMD_BOOT;
            else if (line_holds(slcr_pkg::WORD_RESET, slcr_pkg::RESET_LEN))
                res.code = slcr_pkg::CMD_RESET;
            else if (line_holds(slcr_pkg::WORD_STATS, slcr_pkg::STATS_LEN))
                res.code = slcr_pkg::CMD_STATS;
            line_len = 0;
        end else if (line_len < slcr_pkg::LINE_DEPTH) begin
            line_text[line_len] = rx_char;
            line_len++;
        end else begin
            // full line: drop the character and start over
            line_len = 0;
            overflow_drops++;
        end
        return res;
    endfunction

    // ------------------------------------------------------------------------
    // Sender: one word per call, bursts separated by random gaps
    // ------------------------------------------------------------------------
    task automatic send_char(input logic [7:0] rx_char, input logic err);
        int gap;
        if (burst_left == 0) begin
            gap = $urandom_range(0, 12);
            if (gap > 0) begin
                in_if.valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        in_if.valid      <= 1'b1;
        in_if.rx_byte    <= rx_char;
        in_if.line_error <= err;
        do @(posedge i_clk); while (!in_if.ready);
        pending_results.push_back(predict_line_result(rx_char, err));
        words_sent++;
        burst_left--;
    endtask

    task automatic send_text(input string text);
        for (int i = 0; i < text.len(); i++) send_char(text[i], 1'b0);
    endtask

    function automatic string command_text(input int sel);
        case (sel)
            0:       return "@BOOT";
            1:       return "@RESET";
            default: return "@STATS";
        endcase
    endfunction

    function automatic logic [7:0] printable_char();
        return 8'($urandom_range(8'h20, 8'h7E));
    endfunction

    // Command text with carriage returns sprinkled in, then a line feed
    task automatic send_command_line(input string text);
        for (int i = 0; i < text.len(); i++) begin
            if ($urandom_range(0, 7) == 0) send_char(slcr_pkg::CHAR_CR, 1'b0);
            send_char(text[i], 1'b0);
        end
        if ($urandom_range(0, 3) == 0) send_char(slcr_pkg::CHAR_CR, 1'b0);
        send_char(slcr_pkg::CHAR_LF, 1'b0);
    endtask

    task automatic wait_drained();
        while (pending_results.size() != 0) @(posedge i_clk);
    endtask

    // ------------------------------------------------------------------------
    // Result checker
    // ------------------------------------------------------------------------
    task automatic check_line_result(input logic [1:0] got_code, input logic got_restart);
        t_line_result want;
        results_seen++;
        if (pending_results.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= MAX_REPORTS)
                $display("unexpected result word: code %0d restart %0b",
                         got_code, got_restart);
            return;
        end
        want = pending_results.pop_front();
        if (got_code !== want.code || got_restart !== want.restart) begin
            mismatch_count++;
            if (mismatch_count <= MAX_REPORTS)
                $display("result %0d: expected code %0d restart %0b, got code %0d restart %0b",
                         results_seen, want.code, want.restart, got_code, got_restart);
        end
        case (want.code)
            slcr_pkg::CMD_BOOT:  boot_seen++;
            slcr_pkg::CMD_RESET: reset_seen++;
            slcr_pkg::CMD_STATS: stats_seen++;
            default: ;
        endcase
        if (want.restart) restart_seen++;
    endtask

    // Receiver: check taken words, then pick next ready from the stall pattern
    always @(posedge i_clk) begin
        if (i_rst_n && out_if.valid && out_if.ready)
            check_line_result(out_if.command_code, out_if.restart_request);

        if (rx_mode_left == 0) begin
            rx_mode      = $urandom_range(0, 3);
            rx_mode_left = $urandom_range(20, 200);
        end
        rx_mode_left--;
        rx_phase++;
        case (rx_mode)
            0:       out_if.ready <= 1'b1;
            1:       out_if.ready <= 1'($urandom_range(0, 1));
            2:       out_if.ready <= (rx_phase % 4) == 0;
            default: out_if.ready <= (rx_phase % 32) >= 24;
        endcase
    end

    // Watchdog: too long without any word moving on either channel
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("no progress for %0d cycles, %0d results outstanding",
                         IDLE_LIMIT, pending_results.size());
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // All three commands, one with a carriage return inside the word
    task automatic test_commands();
        send_text("@BO");
        send_char(slcr_pkg::CHAR_CR, 1'b0);
        send_text("OT");
        send_char(slcr_pkg::CHAR_LF, 1'b0);
        send_text("@RESET");
        send_char(slcr_pkg::CHAR_LF, 1'b0);
        send_text("@STATS");
        send_char(slcr_pkg::CHAR_LF, 1'b0);
    endtask

    // Byte extremes, a receive error carrying a line feed, an empty line
    task automatic test_edge_words();
        send_char(8'h00, 1'b0);
        send_char(8'hFF, 1'b0);
        send_char(slcr_pkg::CHAR_LF, 1'b1);
        send_char(slcr_pkg::CHAR_LF, 1'b0);
    endtask

    // Command lines, clean or broken in various ways, plus random bytes
    task automatic test_random_lines(input int target);
        string text;
        int    pick, pos, fill;
        while (words_sent < target) begin
            pick = $urandom_range(0, 99);
            text = command_text($urandom_range(0, 2));
            if (pick < 40) begin
                send_command_line(text);
            end else if (pick < 52) begin
                // one character replaced by any byte
                pos       = $urandom_range(0, text.len() - 1);
                text[pos] = 8'($urandom_range(0, 255));
                send_command_line(text);
            end else if (pick < 60) begin
                // one character short or one too many
                if ($urandom_range(0, 1))
                    send_command_line(text.substr(0, text.len() - 2));
                else begin
                    send_text(text);
                    send_char(printable_char(), 1'b0);
                    send_char(slcr_pkg::CHAR_LF, 1'b0);
                end
            end else if (pick < 72) begin
                // long filler around the full-line boundary, maybe a command after
                fill = $urandom_range(slcr_pkg::LINE_DEPTH - 1, slcr_pkg::LINE_DEPTH + 3);
                repeat (fill) send_char(printable_char(), 1'b0);
                if ($urandom_range(0, 1))
                    send_command_line(text);
                else
                    send_char(slcr_pkg::CHAR_LF, 1'b0);
            end else if (pick < 82) begin
                // receive error part way through a line, then the command
                pos = $urandom_range(0, text.len());
                send_text(text.substr(0, pos - 1));
                send_char(8'($urandom_range(0, 255)), 1'b1);
                send_command_line(text);
            end else if (pick < 90) begin
                // garbage prefix spoils the command
                repeat ($urandom_range(1, 4)) send_char(printable_char(), 1'b0);
                send_command_line(text);
            end else begin
                repeat ($urandom_range(1, 8))
                    send_char(8'($urandom_range(0, 255)), 1'($urandom_range(0, 15) == 0));
            end
        end
    endtask

    // Unstructured bytes over the whole range
    task automatic test_random_noise(input int count);
        repeat (count)
            send_char(8'($urandom_range(0, 255)), 1'($urandom_range(0, 15) == 0));
    endtask

    // ------------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------------
    initial begin
        i_rst_n          = 1'b0;
        in_if.valid      = 1'b0;
        in_if.rx_byte    = 8'h00;
        in_if.line_error = 1'b0;
        out_if.ready     = 1'b0;
        line_len         = 0;
        words_sent       = 0;
        burst_left       = 0;
        mismatch_count   = 0;
        results_seen     = 0;
        boot_seen        = 0;
        reset_seen       = 0;
        stats_seen       = 0;
        restart_seen     = 0;
        overflow_drops   = 0;
        idle_cycles      = 0;
        rx_mode          = 0;
        rx_mode_left     = 0;
        rx_phase         = 0;

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_commands();
        test_edge_words();
        test_random_lines(TOTAL_WORDS - NOISE_WORDS);
        test_random_noise(NOISE_WORDS);

        in_if.valid <= 1'b0;
        wait_drained();
        repeat (5) @(posedge i_clk);

        if (pending_results.size() != 0) begin
            mismatch_count++;
            $display("%0d predicted results never returned", pending_results.size());
        end

        $display("sent %0d words, checked %0d results; %0d mismatches", words_sent,
                 results_seen, mismatch_count);
        $display("lines matched: boot %0d, reset %0d, stats %0d;",
                 boot_seen, reset_seen, stats_seen);
        $display("restarts %0d, full-line drops %0d", restart_seen, overflow_drops);
        if (mismatch_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
